[sv/pioo_pkg.sv]
// Package with the constants and the hash function of the persistent-item sketch.
`timescale 1ns / 1ps
package pioo_pkg;
    localparam int unsigned NumBuckets = 16;
    localparam int unsigned Ways = 2;
    localparam int unsigned BucketBits = $clog2(NumBuckets);
    localparam int unsigned WayBits = (Ways > 1) ? $clog2(Ways) : 1;
    localparam logic [31:0] HashMul = 32'h045d9f3b;
    localparam int unsigned HashShift = 16;
    localparam logic [15:0] WindowReset = 16'd100;

    // One entry of a bucket as it is held in memory.
    typedef struct packed {
        logic        used;
        logic        armed;
        logic [31:0] key;
        logic [31:0] count;
    } entry_t;

    typedef struct packed {
        logic        armed;
        logic [31:0] key;
        logic [31:0] count;
    } spare_t;

    localparam int unsigned BucketWidth = Ways * $bits(entry_t) + $bits(spare_t);

    typedef struct packed {
        entry_t [Ways-1:0] entries;
        spare_t            spare;
    } bucket_t;

    function automatic logic [31:0] mix_step(input logic [31:0] v);
        logic [31:0] x;
        begin
            x = (v >> HashShift) ^ v;
            return x * HashMul;
        end
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        begin
            return (v == 32'hffffffff) ? v : v + 32'd1;
        end
    endfunction
endpackage

[sv/pioo_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pioo_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/persistent_item_onoff_sketch.sv]
// Top level of the persistent-item on/off sketch.
// Each key is hashed in two registered multiply stages, then its bucket is read from a
// memory with registered read data, updated and written back. One item is handled at a
// time. An item goes through these steps in order: acceptance with the first hash stage,
// the second hash stage, the memory read, the update and write back, and the presentation
// of the result, which holds while the receiver stalls. After reset a clearing pass writes
// zeros to all NumBuckets (16) buckets before the first item is taken.
// Window re-arming uses a stale flag per bucket. When a window closes, every stale flag is
// set. A bucket whose stale flag is set reads with all its armed flags set. Writing a bucket
// back after an item clears its stale flag, unless that item closes the window.
`timescale 1ns / 1ps
module persistent_item_onoff_sketch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tracked,
    output logic [31:0] persistence,
    output logic        window_end
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH2 = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam int unsigned MemWidth = pioo_pkg::BucketWidth;

    logic [2:0]  state_reg, state_next;
    logic [15:0] window_length_reg;
    logic [15:0] pos_reg;
    logic [pioo_pkg::NumBuckets-1:0] stale_reg;
    logic [pioo_pkg::BucketBits:0] clr_reg;
    logic [31:0] key_reg;
    logic [31:0] hash_reg;
    logic [pioo_pkg::BucketBits-1:0] bucket;
    logic        tracked_reg, wend_reg;
    logic [31:0] pers_reg;

    logic                    mem_we;
    logic [pioo_pkg::BucketBits-1:0] mem_waddr;
    logic [MemWidth-1:0]     mem_wdata, mem_rdata;
    pioo_pkg::bucket_t       cur, upd;
    logic                    r_tracked;
    logic [31:0]             r_pers;
    logic                    r_wend;
    logic [15:0]             pos_inc;
    logic [16:0]             limit;

    // The last xor of the hash only touches the low bits through the upper half.
    assign bucket = hash_reg[pioo_pkg::BucketBits-1:0]
                  ^ hash_reg[pioo_pkg::HashShift +: pioo_pkg::BucketBits];

    pioo_ram #(.Width(MemWidth), .Depth(pioo_pkg::NumBuckets)) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(bucket),
        .rdata(mem_rdata)
    );

    // A set stale flag means reset came or the window closed since the last write: flags read armed.
    always_comb
    begin
        cur = pioo_pkg::bucket_t'(mem_rdata);
        if (stale_reg[bucket])
        begin
            for (int w = 0; w < pioo_pkg::Ways; w++)
            begin
                cur.entries[w].armed = 1'b1;
            end
            cur.spare.armed = 1'b1;
        end
    end

    always_comb
    begin
        logic hit_found, free_found, swapped;
        logic [pioo_pkg::WayBits-1:0] hit_w, free_w;
        logic [31:0] sc;
        pioo_pkg::entry_t old;
        upd = cur;
        hit_found = 1'b0;
        free_found = 1'b0;
        swapped = 1'b0;
        hit_w = '0;
        free_w = '0;
        sc = cur.spare.count;
        old = cur.entries[0];
        r_tracked = 1'b0;
        r_pers = cur.spare.count;
        for (int w = 0; w < pioo_pkg::Ways; w++)
        begin
            if (cur.entries[w].used && cur.entries[w].key == key_reg && !hit_found)
            begin
                hit_found = 1'b1;
                hit_w = pioo_pkg::WayBits'(w);
            end
            if (!cur.entries[w].used && !free_found)
            begin
                free_found = 1'b1;
                free_w = pioo_pkg::WayBits'(w);
            end
        end
        if (hit_found)
        begin
            if (cur.entries[hit_w].armed)
            begin
                upd.entries[hit_w].armed = 1'b0;
                upd.entries[hit_w].count = pioo_pkg::sat_inc(cur.entries[hit_w].count);
            end
            r_tracked = 1'b1;
            r_pers = upd.entries[hit_w].count;
        end
        else if (free_found)
        begin
            upd.entries[free_w].used = 1'b1;
            upd.entries[free_w].armed = 1'b0;
            upd.entries[free_w].key = key_reg;
            upd.entries[free_w].count = 32'd1;
            r_tracked = 1'b1;
            r_pers = 32'd1;
        end
        else if (cur.spare.armed)
        begin
            sc = pioo_pkg::sat_inc(cur.spare.count);
            upd.spare.armed = 1'b0;
            upd.spare.count = sc;
            r_pers = sc;
            for (int w = 0; w < pioo_pkg::Ways; w++)
            begin
                if (!swapped && cur.entries[w].count < sc)
                begin
                    swapped = 1'b1;
                    old = cur.entries[w];
                    upd.entries[w].key = key_reg;
                    upd.entries[w].count = sc;
                    upd.entries[w].armed = 1'b0;
                    upd.spare.key = old.key;
                    upd.spare.count = old.count;
                    upd.spare.armed = old.armed;
                    r_tracked = 1'b1;
                end
            end
        end
    end

    assign limit = (window_length_reg == 16'd0) ? 17'h10000 : {1'b0, window_length_reg};
    assign pos_inc = pos_reg + 16'd1;
    assign r_wend = ({1'b0, pos_reg} + 17'd1) >= limit;

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = bucket;
        mem_wdata = upd;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_reg[pioo_pkg::BucketBits-1:0];
            mem_wdata = '0;
        end
        else if (state_reg == ST_UPD)
        begin
            mem_we = 1'b1;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign tracked = tracked_reg;
    assign persistence = pers_reg;
    assign window_end = wend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (pioo_pkg::BucketBits + 1)'(pioo_pkg::NumBuckets - 1))
                          state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_HASH2;
            ST_HASH2: state_next = ST_READ;
            ST_READ:  state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            window_length_reg <= pioo_pkg::WindowReset;
            pos_reg <= '0;
            stale_reg <= '1;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + (pioo_pkg::BucketBits + 1)'(1);
            end
            if (state_reg == ST_UPD)
            begin
                if (r_wend)
                begin
                    pos_reg <= '0;
                    stale_reg <= '1;
                end
                else
                begin
                    pos_reg <= pos_inc;
                    stale_reg[bucket] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg <= key;
            hash_reg <= pioo_pkg::mix_step(key);
        end
        if (state_reg == ST_HASH2)
        begin
            hash_reg <= pioo_pkg::mix_step(hash_reg);
        end
        if (state_reg == ST_UPD)
        begin
            tracked_reg <= r_tracked;
            pers_reg <= r_pers;
            wend_reg <= r_wend;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");
    a_out_follows_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |=> out_valid) else $error("result missing after update");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && wend_reg) |-> pos_reg == 16'd0)
        else $error("window not reset");
`endif
endmodule
